/* design/cdd_pkg.sv */
// Shared types, codes and CRC helpers for the CRC-7 delimited packet deframer.
package cdd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_DELIM   = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_STOPPED = 3'b100
  } phase_t;

  // Result kind codes as seen on the result channel.
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_END       = 3'd2,
    KIND_BAD_DELIM = 3'd3,
    KIND_LIMIT     = 3'd4,
    KIND_DISCARD   = 3'd5
  } kind_t;

  // Register index of packet_limit, taken from paddr[2].
  localparam logic REG_PACKET_LIMIT = 1'b0;
  localparam logic [7:0] PACKET_LIMIT_RESET = 8'd64;

  // x^7 + x^3 + 1 without the leading term.
  localparam logic [6:0] CRC7_POLY = 7'h09;

  typedef struct packed {
    logic ok;    // CRC, size and padding all check out
    logic zero;  // end-of-stream word
  } delim_chk_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word_data;
    logic [13:0] packet_size;
    logic [2:0]  pool_id;
    logic [2:0]  valid_bytes;
    logic        end_of_packet;
    logic [7:0]  packets_taken;
  } res_t;

  // Bit-serial CRC-7 over a 25-bit message, most significant bit first.
  function automatic logic [6:0] crc7_serial(input logic [24:0] msg);
    logic [6:0] c;
    logic       fb;
    c = '0;
    for (int i = 24; i >= 0; i--) begin
      fb = c[6] ^ msg[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

  // Message bits that feed CRC bit j; evaluated at elaboration only.
  function automatic logic [24:0] crc7_mask(input int unsigned j);
    logic [24:0] m;
    logic [6:0]  r;
    m = '0;
    for (int i = 0; i < 25; i++) begin
      r    = crc7_serial(25'(1) << i);
      m[i] = r[j];
    end
    return m;
  endfunction

endpackage

/* design/cdd_ifs.sv */
// Request and result channel interfaces of the deframer.
interface cdd_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] stream_word;
  logic        burst_start;

  modport source (output valid, output stream_word, output burst_start, input ready);
  modport sink (input valid, input stream_word, input burst_start, output ready);
endinterface

interface cdd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] word_data;
  logic [13:0] packet_size;
  logic [2:0]  pool_id;
  logic [2:0]  valid_bytes;
  logic        end_of_packet;
  logic [7:0]  packets_taken;

  modport source (
    output valid, output kind, output word_data, output packet_size, output pool_id,
    output valid_bytes, output end_of_packet, output packets_taken, input ready
  );
  modport sink (
    input valid, input kind, input word_data, input packet_size, input pool_id,
    input valid_bytes, input end_of_packet, input packets_taken, output ready
  );
endinterface

/* design/cdd_cfg.sv */
// APB-style configuration register block holding the per-burst packet limit.
module cdd_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  packet_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_limit <= cdd_pkg::PACKET_LIMIT_RESET;
    end else if (wr_en && paddr[2] == cdd_pkg::REG_PACKET_LIMIT) begin
      packet_limit <= pwdata[7:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      cdd_pkg::REG_PACKET_LIMIT: prdata = {24'd0, packet_limit};
      default:                   prdata = '0;
    endcase
  end

endmodule

/* design/cdd_delim_chk.sv */
// Delimiter checker: CRC-7, size, length bound and padding checks of one word.
module cdd_delim_chk #(
  parameter int unsigned MAX_PACKET_BYTES = 16384
) (
  input  logic [31:0]         word,
  output cdd_pkg::delim_chk_t chk
);

  localparam logic [14:0] MAX_BYTES = 15'(MAX_PACKET_BYTES);

  logic [6:0]  crc;
  logic [13:0] size;
  logic [1:0]  pad;
  logic [1:0]  need;
  logic [14:0] padded;

  // Each CRC bit is a fixed XOR of message bits.
  for (genvar j = 0; j < 7; j++) begin : g_crc
    localparam logic [24:0] Mask = cdd_pkg::crc7_mask(j);
    assign crc[j] = ^(word[24:0] & Mask);
  end

  assign size   = word[13:0];
  assign pad    = word[18:17];
  assign need   = 2'(~size[1:0] + 2'd1);
  assign padded = {1'b0, size} + {13'd0, pad};

  assign chk.zero = (word == 32'd0);
  assign chk.ok   = (crc == word[31:25]) && (size != 14'd0) &&
                    (padded <= MAX_BYTES) && (need == pad);

endmodule

/* design/cdd_parser.sv */
// Parser state and result formation for one word per cycle while take is high.
module cdd_parser #(
  parameter int unsigned WORDS_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [31:0]         word,
  input  logic                burst_start,
  input  logic [7:0]          packet_limit,
  input  cdd_pkg::delim_chk_t chk,
  output cdd_pkg::res_t       res
);

  cdd_pkg::phase_t    phase, phase_next, ph_eff;
  logic [WORDS_W-1:0] words_left, words_left_next;
  logic [2:0]         tail_bytes, tail_bytes_next;
  logic [7:0]         packets_seen, packets_seen_next, ps_eff;
  logic [2:0]         held_pool, held_pool_next;
  logic [13:0]        held_size, held_size_next;
  logic [14:0]        padded;

  assign padded = {1'b0, word[13:0]} + {13'd0, word[18:17]};

  always_comb begin
    ps_eff = burst_start ? 8'd0 : packets_seen;
    ph_eff = phase;
    if (burst_start && phase != cdd_pkg::PH_DELIM && phase != cdd_pkg::PH_PAYLOAD) begin
      ph_eff = cdd_pkg::PH_DELIM;
    end

    phase_next        = ph_eff;
    words_left_next   = words_left;
    tail_bytes_next   = tail_bytes;
    packets_seen_next = ps_eff;
    held_pool_next    = held_pool;
    held_size_next    = held_size;

    res               = '0;
    res.kind          = cdd_pkg::KIND_DISCARD;

    unique case (ph_eff)
      cdd_pkg::PH_DELIM: begin
        if (ps_eff >= packet_limit) begin
          res.kind   = cdd_pkg::KIND_LIMIT;
          phase_next = cdd_pkg::PH_STOPPED;
        end else if (chk.zero) begin
          res.kind   = cdd_pkg::KIND_END;
          phase_next = cdd_pkg::PH_STOPPED;
        end else if (!chk.ok) begin
          res.kind   = cdd_pkg::KIND_BAD_DELIM;
          phase_next = cdd_pkg::PH_STOPPED;
        end else begin
          held_size_next    = word[13:0];
          held_pool_next    = word[16:14];
          tail_bytes_next   = {1'b0, word[1:0]};
          words_left_next   = WORDS_W'(padded >> 2);
          packets_seen_next = (ps_eff == 8'hff) ? ps_eff : 8'(ps_eff + 8'd1);
          res.kind          = cdd_pkg::KIND_HEADER;
          res.packet_size   = word[13:0];
          res.pool_id       = word[16:14];
          phase_next        = (words_left_next != '0) ? cdd_pkg::PH_PAYLOAD
                                                      : cdd_pkg::PH_DELIM;
        end
      end
      cdd_pkg::PH_PAYLOAD: begin
        res.kind        = cdd_pkg::KIND_PAYLOAD;
        res.word_data   = word;
        res.packet_size = held_size;
        res.pool_id     = held_pool;
        if (words_left <= WORDS_W'(1)) begin
          res.valid_bytes   = (tail_bytes != 3'd0) ? tail_bytes : 3'd4;
          res.end_of_packet = 1'b1;
          words_left_next   = '0;
          phase_next        = cdd_pkg::PH_DELIM;
        end else begin
          res.valid_bytes = 3'd4;
          words_left_next = words_left - WORDS_W'(1);
        end
      end
      default: begin
        res.kind = cdd_pkg::KIND_DISCARD;
      end
    endcase

    res.packets_taken = packets_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cdd_pkg::PH_DELIM;
      words_left   <= '0;
      tail_bytes   <= '0;
      packets_seen <= '0;
      held_pool    <= '0;
      held_size    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      words_left   <= words_left_next;
      tail_bytes   <= tail_bytes_next;
      packets_seen <= packets_seen_next;
      held_pool    <= held_pool_next;
      held_size    <= held_size_next;
    end
  end

endmodule

/* design/cdd_out_reg.sv */
// Result register that drives the result channel.
module cdd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  cdd_pkg::res_t res,
  cdd_res_if.source     res_out
);

  logic          full;
  cdd_pkg::res_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (res_out.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign res_out.valid         = full;
  assign res_out.kind          = held.kind;
  assign res_out.word_data     = held.word_data;
  assign res_out.packet_size   = held.packet_size;
  assign res_out.pool_id       = held.pool_id;
  assign res_out.valid_bytes   = held.valid_bytes;
  assign res_out.end_of_packet = held.end_of_packet;
  assign res_out.packets_taken = held.packets_taken;

endmodule

/* design/crc7_delimited_packet_deframer_top.sv */
// Top level of the CRC-7 delimited packet deframer.
//
//   Channel   Dir  Handshake          Carries
//   req_in    in   valid/ready        stream_word, burst_start
//   res_out   out  valid/ready        kind, word_data, packet_size, pool_id,
//                                     valid_bytes, end_of_packet, packets_taken
//   APB       in   psel/penable       packet_limit register at byte address 0
//
// Every request produces exactly one result. A request is captured in the input
// register, checked and parsed combinationally, and lands in the result register,
// so one request can be taken every cycle while res_out is not stalled.
// The rate is set by the combinational path from the input register through the
// CRC and delimiter checks into the result register.
// Reset (synchronous, active high) empties both registers, puts the parser in the
// delimiter phase with a zero packet count, and sets packet_limit to 64.
// When res_out is stalled, the result register holds and the input register
// still takes one more request before req_in.ready drops.
module crc7_delimited_packet_deframer_top #(
  parameter int unsigned MAX_PACKET_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  cdd_req_if.sink     req_in,
  cdd_res_if.source   res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Width of the payload word count of the longest packet, padding included.
  localparam int unsigned WORDS_W = $clog2(MAX_PACKET_BYTES / 4 + 1);

  logic                in_full;
  logic [31:0]         in_word;
  logic                in_burst;
  logic                move;
  logic [7:0]          packet_limit;
  cdd_pkg::delim_chk_t chk;
  cdd_pkg::res_t       res;

  // The request in the input register moves on whenever the result register is
  // free or is being emptied in this same cycle.
  assign move         = in_full && (!res_out.valid || res_out.ready);
  assign req_in.ready = !in_full || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_in.valid && req_in.ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_in.valid && req_in.ready) begin
      in_word  <= req_in.stream_word;
      in_burst <= req_in.burst_start;
    end
  end

  cdd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .packet_limit (packet_limit)
  );

  // The checker always looks at the held word; the parser decides whether a
  // delimiter is actually due.
  cdd_delim_chk #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_chk (
    .word (in_word),
    .chk  (chk)
  );

  // Parser state advances exactly when a request hands its result over.
  cdd_parser #(
    .WORDS_W (WORDS_W)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (move),
    .word         (in_word),
    .burst_start  (in_burst),
    .packet_limit (packet_limit),
    .chk          (chk),
    .res          (res)
  );

  cdd_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (move),
    .res     (res),
    .res_out (res_out)
  );

  // A stalled result must keep the held request in the input register.
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_full && res_out.valid && !res_out.ready |=> in_full)
    else $error("input request lost while result stalled");

  // An end mark only comes on a payload word with at least one byte.
  a_eop_payload: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.end_of_packet |->
      res_out.kind == cdd_pkg::KIND_PAYLOAD && res_out.valid_bytes != 3'd0)
    else $error("end of packet on a non-payload result");

  // A header never announces an empty packet.
  a_header_size: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.kind == cdd_pkg::KIND_HEADER |-> res_out.packet_size != 14'd0)
    else $error("header with zero packet size");

  // Partial words only appear at the end of a packet.
  a_partial_is_last: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.kind == cdd_pkg::KIND_PAYLOAD && res_out.valid_bytes != 3'd4
      |-> res_out.end_of_packet)
    else $error("partial payload word before end of packet");

endmodule
